// ----- hdl/mesh_warp_source_address_defines.svh -----
// Assertion macros for the mesh warp source address block.
// Used by the top level only; no other dependencies.
`ifndef MESH_WARP_SOURCE_ADDRESS_DEFINES_SVH
`define MESH_WARP_SOURCE_ADDRESS_DEFINES_SVH
`ifndef SYNTH
`define MWSA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MWSA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define MWSA_ASSERT(lbl, clk, rst, prop, msg)
`define MWSA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hdl/mwsa_pkg.sv -----
// Shared types and constants for the mesh warp source address block.
// No dependencies.
package mwsa_pkg;

   localparam int PIX_W     = 12;   // pixel coordinate
   localparam int DIM_W     = 13;   // image dimension register
   localparam int MESH_W    = 5;    // mesh rows/cols register
   localparam int PT_W      = 20;   // control point coordinate, 4 fraction bits
   localparam int IDX_W     = 4;    // control point row/col
   localparam int UV_W      = 16;   // cell-local fraction
   localparam int SRC_FRAC  = 36;   // fraction bits of the source coordinate
   localparam int WT_W      = 8;    // fetch weight
   localparam int DIF_W     = PT_W + 1;
   localparam int TW        = 38;   // row blend (top/bottom) and its difference
   localparam int LO_W      = 19;   // low split of the row difference
   localparam int PL_W      = LO_W + UV_W;
   localparam int PH_W      = TW - LO_W + UV_W + 1;
   localparam int SW        = 54;   // source coordinate
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 13;

   localparam int MAX_MESH_ROWS_DEF = 16;
   localparam int MAX_MESH_COLS_DEF = 16;
   localparam int MAX_IMAGE_DIM_DEF = 4096;

   localparam logic [DIM_W-1:0]  WIDTH_RST  = 13'd1024;
   localparam logic [DIM_W-1:0]  HEIGHT_RST = 13'd1024;
   localparam logic [MESH_W-1:0] ROWS_RST   = 5'd4;
   localparam logic [MESH_W-1:0] COLS_RST   = 5'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MESH_ROWS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MESH_COLS    = 3'd3;

   // operations
   localparam logic OP_WRITE_POINT = 1'b0;
   localparam logic OP_MAP_PIXEL   = 1'b1;

   // request as it travels to the control point table
   typedef struct packed {
      logic                    valid;
      logic                    op;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [PT_W-1:0]  ptx;
      logic signed [PT_W-1:0]  pty;
      logic [PIX_W-1:0]        px;
      logic [PIX_W-1:0]        py;
   } sb_type;

   // pixel request after the table
   typedef struct packed {
      logic             valid;
      logic [PIX_W-1:0] px;
      logic [PIX_W-1:0] py;
   } pix_type;

endpackage

// ----- hdl/mwsa_locate.sv -----
// Pipelined cell locator: floor(pos*nm1*2^16 / dim), one quotient bit per stage.
// Depends on mwsa_pkg.
module mwsa_locate import mwsa_pkg::*; #(
   parameter int NW = 5,
   parameter int CW = 4
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [PIX_W-1:0]      pos,
   input  logic [DIM_W-1:0]      dim,
   input  logic [NW-1:0]         nm1,
   output logic [CW+UV_W-1:0]    quot
);

   localparam int QW   = CW + UV_W;
   localparam int NUMW = PIX_W + NW;
   localparam int RW   = DIM_W;

   logic [NUMW-1:0] num_ff;
   logic [NUMW-1:0] num_in;
   logic [RW-1:0]   r_ff   [QW];
   logic [QW-1:0]   dlo_ff [QW];
   logic [QW-1:0]   q_ff   [QW];

   // numerator: pixel times cell count
   assign num_in = {{NW{1'b0}}, pos} * {{PIX_W{1'b0}}, nm1};

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
      end
   end

   // restoring division, one bit per stage
   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [RW-1:0] r_prev;
      logic [QW-1:0] dlo_prev;
      logic [QW-1:0] q_prev;
      logic [RW:0]   t;
      logic          ge;

      if (k == 0) begin : g_first
         assign r_prev   = RW'(num_ff >> CW);
         assign dlo_prev = {num_ff[CW-1:0], {UV_W{1'b0}}};
         assign q_prev   = '0;
      end else begin : g_next
         assign r_prev   = r_ff[k-1];
         assign dlo_prev = dlo_ff[k-1];
         assign q_prev   = q_ff[k-1];
      end

      assign t  = {r_prev, dlo_prev[QW-1]};
      assign ge = t >= {1'b0, dim};

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k]   <= ge ? RW'(t - {1'b0, dim}) : RW'(t);
            dlo_ff[k] <= dlo_prev << 1;
            q_ff[k]   <= {q_prev[QW-2:0], ge};
         end
      end
   end

   assign quot = q_ff[QW-1];

endmodule

// ----- hdl/mesh_warp_source_address.sv -----
// Path from request to result: input register, the bit-per-stage cell divider, the control
// point table and the six blend stages behind the table.
// Throughput: one request per cycle; a stalled result freezes the whole pipeline.
// Reset: synchronous, clears valid bits and loads the default configuration;
// the control point table is not cleared and must be written before use.
`include "mesh_warp_source_address_defines.svh"
module mesh_warp_source_address import mwsa_pkg::*; #(
   parameter int MAX_MESH_ROWS = MAX_MESH_ROWS_DEF,
   parameter int MAX_MESH_COLS = MAX_MESH_COLS_DEF,
   parameter int MAX_IMAGE_DIM = MAX_IMAGE_DIM_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DAT_W-1:0]   csr_data,
   // request
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_operation,
   input  logic [IDX_W-1:0]       req_point_row,
   input  logic [IDX_W-1:0]       req_point_col,
   input  logic signed [PT_W-1:0] req_point_x,
   input  logic signed [PT_W-1:0] req_point_y,
   input  logic [PIX_W-1:0]       req_pixel_x,
   input  logic [PIX_W-1:0]       req_pixel_y,
   // result
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_inside_res,
   output logic [PIX_W-1:0]       rsp_left_col,
   output logic [PIX_W-1:0]       rsp_right_col,
   output logic [PIX_W-1:0]       rsp_top_row,
   output logic [PIX_W-1:0]       rsp_bottom_row,
   output logic [WT_W-1:0]        rsp_weight_x,
   output logic [WT_W-1:0]        rsp_weight_y
);

   localparam int CXW   = (MAX_MESH_COLS > 2) ? $clog2(MAX_MESH_COLS - 1) : 1;
   localparam int CYW   = (MAX_MESH_ROWS > 2) ? $clog2(MAX_MESH_ROWS - 1) : 1;
   localparam int CW    = (CXW > CYW) ? CXW : CYW;
   localparam int NCW   = $clog2(MAX_MESH_COLS + 1);
   localparam int NRW   = $clog2(MAX_MESH_ROWS + 1);
   localparam int NW    = (NCW > NRW) ? NCW : NRW;
   localparam int QW    = CW + UV_W;
   localparam int LAT   = QW + 1;
   localparam int DEPTH = MAX_MESH_ROWS * MAX_MESH_COLS;
   localparam int AW    = $clog2(DEPTH);

   // ---------------------------------------------------------------
   // configuration registers
   logic [DIM_W-1:0]  width_ff, height_ff;
   logic [MESH_W-1:0] rows_ff, cols_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         rows_ff   <= ROWS_RST;
         cols_ff   <= COLS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= csr_data;
            REG_IMAGE_HEIGHT: height_ff <= csr_data;
            REG_MESH_ROWS:    rows_ff   <= MESH_W'(csr_data);
            REG_MESH_COLS:    cols_ff   <= MESH_W'(csr_data);
            default: ;
         endcase
      end
   end

   // effective sizes
   logic [DIM_W-1:0] w_eff, h_eff;
   logic [NW-1:0]    ncol_eff, nrow_eff;
   logic             identity;

   always_comb begin
      if (width_ff == '0)                    w_eff = DIM_W'(1);
      else if (int'(width_ff) > MAX_IMAGE_DIM) w_eff = DIM_W'(MAX_IMAGE_DIM);
      else                                   w_eff = width_ff;
      if (height_ff == '0)                    h_eff = DIM_W'(1);
      else if (int'(height_ff) > MAX_IMAGE_DIM) h_eff = DIM_W'(MAX_IMAGE_DIM);
      else                                    h_eff = height_ff;
      ncol_eff = (int'(cols_ff) > MAX_MESH_COLS) ? NW'(MAX_MESH_COLS) : NW'(cols_ff);
      nrow_eff = (int'(rows_ff) > MAX_MESH_ROWS) ? NW'(MAX_MESH_ROWS) : NW'(rows_ff);
      identity = (rows_ff < MESH_W'(2)) || (cols_ff < MESH_W'(2));
   end

   // ---------------------------------------------------------------
   // pipeline advance
   logic rsp_valid_ff;
   logic en;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // input register
   sb_type sb0_ff, sb0_in;

   always_comb begin
      sb0_in.valid = req_valid;
      sb0_in.op    = req_operation;
      sb0_in.row   = req_point_row;
      sb0_in.col   = req_point_col;
      sb0_in.ptx   = req_point_x;
      sb0_in.pty   = req_point_y;
      sb0_in.px    = req_pixel_x;
      sb0_in.py    = req_pixel_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sb0_ff <= '0;
      end else if (en) begin
         sb0_ff <= sb0_in;
      end
   end

   // cell locators
   logic [QW-1:0] qx, qy;

   mwsa_locate #(.NW(NW), .CW(CW)) u_loc_x (
      .clock (clock),
      .en    (en),
      .pos   (sb0_ff.px),
      .dim   (w_eff),
      .nm1   (NW'(ncol_eff - NW'(1))),
      .quot  (qx)
   );

   mwsa_locate #(.NW(NW), .CW(CW)) u_loc_y (
      .clock (clock),
      .en    (en),
      .pos   (sb0_ff.py),
      .dim   (h_eff),
      .nm1   (NW'(nrow_eff - NW'(1))),
      .quot  (qy)
   );

   // request delay line matching the locators
   sb_type dl_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) dl_ff[i] <= '0;
      end else if (en) begin
         dl_ff[0] <= sb0_ff;
         for (int i = 1; i < LAT; i++) dl_ff[i] <= dl_ff[i-1];
      end
   end

   // ---------------------------------------------------------------
   // control point table: four copies, one per cell corner
   sb_type           dl_last;
   logic [AW-1:0]    a00, a10, a01, a11, wa;
   logic             wr;
   logic [2*PT_W-1:0] wdat;

   assign dl_last = dl_ff[LAT-1];

   always_comb begin
      a00  = AW'(int'(qy[QW-1:UV_W]) * MAX_MESH_COLS + int'(qx[QW-1:UV_W]));
      a10  = AW'(a00 + AW'(1));
      a01  = AW'(int'(a00) + MAX_MESH_COLS);
      a11  = AW'(a01 + AW'(1));
      wa   = AW'(int'(dl_last.row) * MAX_MESH_COLS + int'(dl_last.col));
      wr   = dl_last.valid && (dl_last.op == OP_WRITE_POINT) &&
             (int'(dl_last.row) < MAX_MESH_ROWS) && (int'(dl_last.col) < MAX_MESH_COLS);
      wdat = {dl_last.ptx, dl_last.pty};
   end

   logic [2*PT_W-1:0] mem00 [DEPTH];
   logic [2*PT_W-1:0] mem10 [DEPTH];
   logic [2*PT_W-1:0] mem01 [DEPTH];
   logic [2*PT_W-1:0] mem11 [DEPTH];
   logic [2*PT_W-1:0] rd00_ff, rd10_ff, rd01_ff, rd11_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (wr) begin
            mem00[wa] <= wdat;
            mem10[wa] <= wdat;
            mem01[wa] <= wdat;
            mem11[wa] <= wdat;
         end
         rd00_ff <= mem00[a00];
         rd10_ff <= mem10[a10];
         rd01_ff <= mem01[a01];
         rd11_ff <= mem11[a11];
      end
   end

   // table stage: pixel requests only from here on
   pix_type          pm_ff, pm_in;
   logic [UV_W-1:0]  u_m_ff, v_m_ff;

   always_comb begin
      pm_in.valid = dl_last.valid && (dl_last.op == OP_MAP_PIXEL);
      pm_in.px    = dl_last.px;
      pm_in.py    = dl_last.py;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pm_ff <= '0;
      end else if (en) begin
         pm_ff <= pm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_m_ff <= qx[UV_W-1:0];
         v_m_ff <= qy[UV_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // stage a: corner differences along u
   pix_type                 pa_ff;
   logic signed [PT_W-1:0]  x00_a_ff, x01_a_ff, y00_a_ff, y01_a_ff;
   logic signed [DIF_W-1:0] dxt_a_ff, dxb_a_ff, dyt_a_ff, dyb_a_ff;
   logic [UV_W-1:0]         u_a_ff, v_a_ff;
   logic signed [PT_W-1:0]  x00, x10, x01, x11, y00, y10, y01, y11;

   assign {x00, y00} = rd00_ff;
   assign {x10, y10} = rd10_ff;
   assign {x01, y01} = rd01_ff;
   assign {x11, y11} = rd11_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_ff <= '0;
      end else if (en) begin
         pa_ff <= pm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x00_a_ff <= x00;
         x01_a_ff <= x01;
         y00_a_ff <= y00;
         y01_a_ff <= y01;
         dxt_a_ff <= DIF_W'(x10) - DIF_W'(x00);
         dxb_a_ff <= DIF_W'(x11) - DIF_W'(x01);
         dyt_a_ff <= DIF_W'(y10) - DIF_W'(y00);
         dyb_a_ff <= DIF_W'(y11) - DIF_W'(y01);
         u_a_ff   <= u_m_ff;
         v_a_ff   <= v_m_ff;
      end
   end

   // stage b: blend along u into top and bottom rows
   pix_type              pb_ff;
   logic signed [TW-1:0] tx_b_ff, bx_b_ff, ty_b_ff, by_b_ff;
   logic [UV_W-1:0]      v_b_ff;
   logic signed [TW-1:0] ptx_p, pbx_p, pty_p, pby_p;
   logic signed [UV_W:0] u_s;

   always_comb begin
      u_s   = $signed({1'b0, u_a_ff});
      ptx_p = dxt_a_ff * u_s;
      pbx_p = dxb_a_ff * u_s;
      pty_p = dyt_a_ff * u_s;
      pby_p = dyb_a_ff * u_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pb_ff <= '0;
      end else if (en) begin
         pb_ff <= pa_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tx_b_ff <= (TW'(x00_a_ff) <<< UV_W) + ptx_p;
         bx_b_ff <= (TW'(x01_a_ff) <<< UV_W) + pbx_p;
         ty_b_ff <= (TW'(y00_a_ff) <<< UV_W) + pty_p;
         by_b_ff <= (TW'(y01_a_ff) <<< UV_W) + pby_p;
         v_b_ff  <= v_a_ff;
      end
   end

   // stage c: difference between rows
   pix_type              pc_ff;
   logic signed [TW-1:0] tx_c_ff, dx_c_ff, ty_c_ff, dy_c_ff;
   logic [UV_W-1:0]      v_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else if (en) begin
         pc_ff <= pb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tx_c_ff <= tx_b_ff;
         ty_c_ff <= ty_b_ff;
         dx_c_ff <= bx_b_ff - tx_b_ff;
         dy_c_ff <= by_b_ff - ty_b_ff;
         v_c_ff  <= v_b_ff;
      end
   end

   // stage d: row difference times v, split into two partial products
   pix_type                pd_ff;
   logic signed [TW-1:0]   tx_d_ff, ty_d_ff;
   logic [PL_W-1:0]        plx_d_ff, ply_d_ff;
   logic signed [PH_W-1:0] phx_d_ff, phy_d_ff;
   logic [PL_W-1:0]        plx_p, ply_p;
   logic signed [PH_W-1:0] phx_p, phy_p;
   logic signed [UV_W:0]   v_s;

   always_comb begin
      v_s   = $signed({1'b0, v_c_ff});
      plx_p = dx_c_ff[LO_W-1:0] * v_c_ff;
      ply_p = dy_c_ff[LO_W-1:0] * v_c_ff;
      phx_p = $signed(dx_c_ff[TW-1:LO_W]) * v_s;
      phy_p = $signed(dy_c_ff[TW-1:LO_W]) * v_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pd_ff <= '0;
      end else if (en) begin
         pd_ff <= pc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tx_d_ff  <= tx_c_ff;
         ty_d_ff  <= ty_c_ff;
         plx_d_ff <= plx_p;
         ply_d_ff <= ply_p;
         phx_d_ff <= phx_p;
         phy_d_ff <= phy_p;
      end
   end

   // stage e: source coordinate, or the pixel itself for a degenerate mesh
   pix_type              pe_ff;
   logic signed [SW-1:0] sx_e_ff, sy_e_ff;
   logic signed [SW-1:0] sx_sum, sy_sum;

   always_comb begin
      sx_sum = (SW'(tx_d_ff) <<< UV_W) + (SW'(phx_d_ff) <<< LO_W)
             + $signed(SW'(plx_d_ff));
      sy_sum = (SW'(ty_d_ff) <<< UV_W) + (SW'(phy_d_ff) <<< LO_W)
             + $signed(SW'(ply_d_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pe_ff <= '0;
      end else if (en) begin
         pe_ff <= pd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (identity) begin
            sx_e_ff <= $signed(SW'({pd_ff.px, {SRC_FRAC{1'b0}}}));
            sy_e_ff <= $signed(SW'({pd_ff.py, {SRC_FRAC{1'b0}}}));
         end else begin
            sx_e_ff <= sx_sum;
            sy_e_ff <= sy_sum;
         end
      end
   end

   // ---------------------------------------------------------------
   // stage f: inside test, clamp and fetch addresses
   logic [SW-SRC_FRAC-1:0] hx, hy;
   logic [DIM_W-1:0]       ix, iy, wm1, hm1;
   logic [WT_W-1:0]        fx, fy;
   logic                   lastx, lasty, in_image;

   always_comb begin
      hx     = sx_e_ff[SW-1:SRC_FRAC];
      hy     = sy_e_ff[SW-1:SRC_FRAC];
      ix     = sx_e_ff[SRC_FRAC+DIM_W-1:SRC_FRAC];
      iy     = sy_e_ff[SRC_FRAC+DIM_W-1:SRC_FRAC];
      fx     = sx_e_ff[SRC_FRAC-1:SRC_FRAC-WT_W];
      fy     = sy_e_ff[SRC_FRAC-1:SRC_FRAC-WT_W];
      wm1    = w_eff - DIM_W'(1);
      hm1    = h_eff - DIM_W'(1);
      lastx  = ix == wm1;
      lasty  = iy == hm1;
      in_image = ({1'b0, pe_ff.px} < w_eff) && ({1'b0, pe_ff.py} < h_eff) &&
                 !sx_e_ff[SW-1] && !sy_e_ff[SW-1] &&
                 (hx < (SW-SRC_FRAC)'(w_eff)) && (hy < (SW-SRC_FRAC)'(h_eff));
   end

   logic                inside_ff;
   logic [PIX_W-1:0]    left_ff, right_ff, top_ff, bottom_ff;
   logic [WT_W-1:0]     wx_ff, wy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= pe_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inside_ff <= in_image;
         if (in_image) begin
            left_ff   <= PIX_W'(ix);
            right_ff  <= lastx ? PIX_W'(ix) : PIX_W'(ix + DIM_W'(1));
            top_ff    <= PIX_W'(iy);
            bottom_ff <= lasty ? PIX_W'(iy) : PIX_W'(iy + DIM_W'(1));
            wx_ff     <= lastx ? '0 : fx;
            wy_ff     <= lasty ? '0 : fy;
         end else begin
            left_ff   <= '0;
            right_ff  <= '0;
            top_ff    <= '0;
            bottom_ff <= '0;
            wx_ff     <= '0;
            wy_ff     <= '0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = inside_ff;
   assign rsp_left_col   = left_ff;
   assign rsp_right_col  = right_ff;
   assign rsp_top_row    = top_ff;
   assign rsp_bottom_row = bottom_ff;
   assign rsp_weight_x   = wx_ff;
   assign rsp_weight_y   = wy_ff;

   // ---------------------------------------------------------------
   // checks
   `MWSA_ASSERT_IMP(a_transp_zero, clock, reset, rsp_valid && !rsp_inside_res, rsp_left_col == '0 && rsp_right_col == '0 && rsp_top_row == '0 && rsp_bottom_row == '0 && rsp_weight_x == '0 && rsp_weight_y == '0, "transparent result carries nonzero fields")
   `MWSA_ASSERT_IMP(a_right_adj, clock, reset, rsp_valid && rsp_inside_res, rsp_right_col == rsp_left_col || rsp_right_col == PIX_W'(rsp_left_col + PIX_W'(1)), "right column not next to left column")
   `MWSA_ASSERT_IMP(a_edge_wt, clock, reset, rsp_valid && rsp_inside_res && rsp_bottom_row == rsp_top_row, rsp_weight_y == '0, "weight toward a clamped bottom row")
   `MWSA_ASSERT_IMP(a_left_in, clock, reset, rsp_valid && rsp_inside_res, {1'b0, rsp_left_col} < w_eff, "left column beyond image width")
   `MWSA_ASSERT_IMP(a_rst_empty, clock, reset, $past(reset), !rsp_valid, "result valid right after reset")

endmodule
